// ===== hw/rtl/ltq_pkg.sv =====
`timescale 1ns / 1ps

package ltq_pkg;

  // Table geometry and sample format
  localparam int unsigned MAX_LEVELS = 64;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned IDX_W      = $clog2(MAX_LEVELS);
  localparam int unsigned CNT_W      = $clog2(MAX_LEVELS + 1);

  // One compare step per stage, then a final table read
  localparam int unsigned NSTEP      = $clog2(MAX_LEVELS);
  localparam int unsigned LATENCY    = NSTEP + 2;

  // APB map
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned PDATA_W    = 32;
  localparam logic        REG_LEVEL_COUNT = 1'b0;  // word select paddr[2]
  localparam logic [CNT_W-1:0] LEVEL_COUNT_RST = CNT_W'(2);

  // Item modes
  localparam logic MODE_LOAD     = 1'b0;
  localparam logic MODE_QUANTIZE = 1'b1;

  typedef struct packed {
    logic                       mode;
    logic [IDX_W-1:0]           level_index;
    logic signed [SAMPLE_W-1:0] level_value;
    logic signed [SAMPLE_W-1:0] sample_real;
    logic signed [SAMPLE_W-1:0] sample_imag;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] quantized_real;
    logic signed [SAMPLE_W-1:0] quantized_imag;
    logic [IDX_W-1:0]           code_real;
    logic [IDX_W-1:0]           code_imag;
  } result_t;

  // Payload of one pipeline stage: the item plus both search windows
  typedef struct packed {
    logic                       mode;
    logic [IDX_W-1:0]           level_index;
    logic signed [SAMPLE_W-1:0] level_value;
    logic signed [SAMPLE_W-1:0] part_re;
    logic signed [SAMPLE_W-1:0] part_im;
    logic [CNT_W-1:0]           lo_re;
    logic [CNT_W-1:0]           hi_re;
    logic [IDX_W-1:0]           mid_re;
    logic [CNT_W-1:0]           lo_im;
    logic [CNT_W-1:0]           hi_im;
    logic [IDX_W-1:0]           mid_im;
  } stage_t;

endpackage

// ===== hw/rtl/level_table_quantizer.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Beat
// -------   ---------  ----------------------  ------------------------------
// item      in         start & !busy           in_item_i (load or quantize)
// result    out        done_o, one cycle       result_o
// config    in/out     psel&penable&pwrite     level_count at paddr 0
//
// One item enters every cycle and busy stays low. A quantize beat's result is
// on done_o once the beat has passed the search stages: one stage per search
// step, each reading its own table copy, plus a final read of the chosen level.
// Loads write each copy in turn. Reset clears the valid bits and sets
// level_count to 2; the table is kept. The receiver cannot stall, so the
// pipeline never holds.

module level_table_quantizer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  ltq_pkg::in_item_t         in_item_i,
  output logic                      done_o,
  output ltq_pkg::result_t          result_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ltq_pkg::PADDR_W-1:0] paddr,
  input  logic [ltq_pkg::PDATA_W-1:0] pwdata,
  output logic [ltq_pkg::PDATA_W-1:0] prdata,
  output logic                      pready
);
  import ltq_pkg::*;

  logic [CNT_W-1:0] level_count_q;
  logic [CNT_W-1:0] count_sat;
  logic [CNT_W-1:0] hi_init;
  logic             cfg_wr;

  stage_t           stage_q [NSTEP+2];
  logic             valid_q [NSTEP+2];
  stage_t           stage_d [NSTEP+2];

  // Registered table reads issued by stage j, consumed by stage j+1
  logic signed [SAMPLE_W-1:0] rd_re_q [NSTEP+1];
  logic signed [SAMPLE_W-1:0] rd_im_q [NSTEP+1];

  // Configuration port
  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_count_q <= LEVEL_COUNT_RST;
    end else if (cfg_wr && (paddr[2] == REG_LEVEL_COUNT)) begin
      level_count_q <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_LEVEL_COUNT) ?
                  {{(PDATA_W-CNT_W){1'b0}}, level_count_q} : '0;

  // Saturate the level count and take the initial upper bound
  always_comb begin
    if (level_count_q < CNT_W'(2)) begin
      count_sat = CNT_W'(2);
    end else if (level_count_q > CNT_W'(MAX_LEVELS)) begin
      count_sat = CNT_W'(MAX_LEVELS);
    end else begin
      count_sat = level_count_q;
    end
    hi_init = {count_sat[CNT_W-1:1], 1'b0};
  end

  // Entry stage
  always_comb begin
    stage_d[0].mode        = in_item_i.mode;
    stage_d[0].level_index = in_item_i.level_index;
    stage_d[0].level_value = in_item_i.level_value;
    stage_d[0].part_re     = in_item_i.sample_real;
    stage_d[0].part_im     = in_item_i.sample_imag;
    stage_d[0].lo_re       = '0;
    stage_d[0].hi_re       = hi_init;
    stage_d[0].mid_re      = '0;
    stage_d[0].lo_im       = '0;
    stage_d[0].hi_im       = hi_init;
    stage_d[0].mid_im      = '0;
  end

  // Search stages: compare against the previous read (not in the first), narrow, read next
  for (genvar j = 0; j <= NSTEP; j++) begin : g_stage
    logic [CNT_W-1:0] lo_re_n, hi_re_n, lo_im_n, hi_im_n;
    logic [IDX_W-1:0] addr_re, addr_im;
    logic signed [SAMPLE_W-1:0] tbl_q [MAX_LEVELS];

    if (j == 0) begin : g_first
      assign lo_re_n = stage_q[j].lo_re;
      assign hi_re_n = stage_q[j].hi_re;
      assign lo_im_n = stage_q[j].lo_im;
      assign hi_im_n = stage_q[j].hi_im;
    end else begin : g_cmp
      logic act_re, act_im, ge_re, ge_im;
      always_comb begin
        act_re  = (stage_q[j].hi_re - stage_q[j].lo_re) > CNT_W'(1);
        act_im  = (stage_q[j].hi_im - stage_q[j].lo_im) > CNT_W'(1);
        ge_re   = stage_q[j].part_re >= rd_re_q[j-1];
        ge_im   = stage_q[j].part_im >= rd_im_q[j-1];
        lo_re_n = (act_re && ge_re)  ? CNT_W'(stage_q[j].mid_re) : stage_q[j].lo_re;
        hi_re_n = (act_re && !ge_re) ? CNT_W'(stage_q[j].mid_re) : stage_q[j].hi_re;
        lo_im_n = (act_im && ge_im)  ? CNT_W'(stage_q[j].mid_im) : stage_q[j].lo_im;
        hi_im_n = (act_im && !ge_im) ? CNT_W'(stage_q[j].mid_im) : stage_q[j].hi_im;
      end
    end

    // Midpoint for the next step, or the chosen code after the last step
    if (j < NSTEP) begin : g_mid
      logic [CNT_W:0] sum_re, sum_im;
      assign sum_re  = {1'b0, lo_re_n} + {1'b0, hi_re_n};
      assign sum_im  = {1'b0, lo_im_n} + {1'b0, hi_im_n};
      assign addr_re = sum_re[IDX_W:1];
      assign addr_im = sum_im[IDX_W:1];
    end else begin : g_code
      assign addr_re = lo_re_n[IDX_W-1:0];
      assign addr_im = lo_im_n[IDX_W-1:0];
    end

    always_comb begin
      stage_d[j+1]        = stage_q[j];
      stage_d[j+1].lo_re  = lo_re_n;
      stage_d[j+1].hi_re  = hi_re_n;
      stage_d[j+1].mid_re = addr_re;
      stage_d[j+1].lo_im  = lo_im_n;
      stage_d[j+1].hi_im  = hi_im_n;
      stage_d[j+1].mid_im = addr_im;
    end

    // Table copy of this stage: load beats write, all beats read
    always_ff @(posedge clk_i) begin
      if (valid_q[j] && (stage_q[j].mode == MODE_LOAD)) begin
        tbl_q[stage_q[j].level_index] <= stage_q[j].level_value;
      end
      rd_re_q[j] <= tbl_q[addr_re];
      rd_im_q[j] <= tbl_q[addr_im];
    end
  end

  // Advance valid bits and payload every cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NSTEP + 2; k++) begin
        valid_q[k] <= 1'b0;
      end
    end else begin
      valid_q[0] <= start && !busy;
      for (int k = 1; k < NSTEP + 2; k++) begin
        valid_q[k] <= valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NSTEP + 2; k++) begin
      stage_q[k] <= stage_d[k];
    end
  end

  // Drive the result beat
  assign done_o = valid_q[NSTEP+1] && (stage_q[NSTEP+1].mode == MODE_QUANTIZE);
  assign result_o.quantized_real = rd_re_q[NSTEP];
  assign result_o.quantized_imag = rd_im_q[NSTEP];
  assign result_o.code_real      = stage_q[NSTEP+1].lo_re[IDX_W-1:0];
  assign result_o.code_imag      = stage_q[NSTEP+1].lo_im[IDX_W-1:0];

endmodule

// ===== hw/rtl/ltq_check.sv =====
`timescale 1ns / 1ps

module ltq_check (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  input  logic                      busy,
  input  ltq_pkg::in_item_t         in_item_i,
  input  logic                      done_o,
  input  ltq_pkg::result_t          result_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ltq_pkg::PADDR_W-1:0] paddr,
  input  logic [ltq_pkg::PDATA_W-1:0] pwdata,
  input  logic [ltq_pkg::PDATA_W-1:0] prdata,
  input  logic                      pready
);
  import ltq_pkg::*;

  // Every quantize beat yields a result on done_o
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (in_item_i.mode == MODE_QUANTIZE)) |-> ##LATENCY done_o)
    else $error("quantize beat produced no result");

  // No result without a quantize beat at the matching edge
  a_no_stray_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy && (in_item_i.mode == MODE_QUANTIZE), LATENCY))
    else $error("result without a matching quantize beat");

  // A level_count write reads back on the next cycle
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && (paddr[2] == REG_LEVEL_COUNT)) |=>
    (!(psel && !pwrite && (paddr[2] == REG_LEVEL_COUNT)) ||
     (prdata[CNT_W-1:0] == $past(pwdata[CNT_W-1:0]))))
    else $error("level_count readback mismatch");

endmodule

bind level_table_quantizer ltq_check u_ltq_check (.*);

// ===== tb/level_table_quantizer_test.sv =====
`timescale 1ns / 1ps

module level_table_quantizer_test;
  import ltq_pkg::*;

  localparam int CLK_PERIOD  = 8;
  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_BEATS = 82;

  // DUT connections, all inputs known from time zero
  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 start     = 1'b0;
  logic                 busy;
  in_item_t             in_item_i = '0;
  logic                 done_o;
  result_t              result_o;
  logic                 psel      = 1'b0;
  logic                 penable   = 1'b0;
  logic                 pwrite    = 1'b0;
  logic [PADDR_W-1:0]   paddr     = '0;
  logic [PDATA_W-1:0]   pwdata    = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  // Predictor state: table and level count as the block should hold them
  logic signed [SAMPLE_W-1:0] level_store [MAX_LEVELS];
  logic [CNT_W-1:0]           level_count_copy = LEVEL_COUNT_RST;
  result_t                    awaited_results [$];

  // Stimulus side: beats waiting for the driver and the table they build
  in_item_t                   queued_beats [$];
  logic signed [SAMPLE_W-1:0] gen_table [MAX_LEVELS];
  int unsigned                gen_levels = 2;
  int unsigned                gap_max    = 3;
  int unsigned                beats_queued;
  int unsigned                idle_left;
  int unsigned                mismatches;
  int unsigned                quiet_cycles;

  level_table_quantizer dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .in_item_i (in_item_i),
    .done_o    (done_o),
    .result_o  (result_o),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Saturate the programmed count into the usable range
  function automatic int unsigned active_levels(logic [CNT_W-1:0] count);
    if (count < 2) return 2;
    if (count > MAX_LEVELS) return MAX_LEVELS;
    return count;
  endfunction

  // Binary search over the table; the top bound depends on count parity
  function automatic logic [IDX_W-1:0] search_code(logic signed [SAMPLE_W-1:0] part);
    int unsigned n, lo, hi, mid;
    n  = active_levels(level_count_copy);
    lo = 0;
    hi = (n % 2 == 1) ? n - 1 : n;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (part >= level_store[mid]) lo = mid;
      else hi = mid;
    end
    return IDX_W'(lo);
  endfunction

  function automatic result_t quantize_sample(in_item_t beat);
    result_t r;
    r.code_real      = search_code(beat.sample_real);
    r.code_imag      = search_code(beat.sample_imag);
    r.quantized_real = level_store[r.code_real];
    r.quantized_imag = level_store[r.code_imag];
    return r;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic void queue_load(int unsigned idx, logic signed [SAMPLE_W-1:0] value);
    in_item_t b;
    b.mode        = MODE_LOAD;
    b.level_index = IDX_W'(idx);
    b.level_value = value;
    b.sample_real = SAMPLE_W'($urandom);
    b.sample_imag = SAMPLE_W'($urandom);
    gen_table[idx] = value;
    queued_beats.push_back(b);
    beats_queued++;
  endfunction

  function automatic void queue_quantize(logic signed [SAMPLE_W-1:0] re,
                                         logic signed [SAMPLE_W-1:0] im);
    in_item_t b;
    b.mode        = MODE_QUANTIZE;
    b.level_index = IDX_W'($urandom);
    b.level_value = SAMPLE_W'($urandom);
    b.sample_real = re;
    b.sample_imag = im;
    queued_beats.push_back(b);
    beats_queued++;
  endfunction

  // Load an ascending table into entries 0..n-1, flat runs included
  function automatic void queue_table(int unsigned n);
    int          level;
    int unsigned stride;
    level  = ($urandom_range(0, 3) == 0) ? -32768 : -32768 + int'($urandom_range(0, 30000));
    stride = 131072 / n;
    for (int unsigned i = 0; i < n; i++) begin
      queue_load(i, SAMPLE_W'(level));
      level += int'($urandom_range(0, stride));
      if (level > 32767) level = 32767;
    end
  endfunction

  // Pick a part: on a level, next to one, at the rails, or anywhere
  function automatic logic signed [SAMPLE_W-1:0] pick_part();
    int unsigned k;
    k = $urandom_range(0, gen_levels - 1);
    case ($urandom_range(0, 5))
      0:       return SAMPLE_W'($urandom);
      1:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      2, 3:    return gen_table[k];
      default: return SAMPLE_W'(int'(gen_table[k]) + int'($urandom_range(0, 6)) - 3);
    endcase
  endfunction

  // Wait until every queued beat is taken and every result has come back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (queued_beats.size() != 0 || start || awaited_results.size() != 0);
  endtask

  // Write level_count over APB, then read it back
  task automatic write_level_count(input logic [CNT_W-1:0] count);
    logic [PDATA_W-1:0] word;
    logic [PDATA_W-1:0] readback;
    word             = $urandom;
    word[CNT_W-1:0]  = count;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_LEVEL_COUNT, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    level_count_copy = count;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    readback = prdata;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== PDATA_W'(count))
      flag_mismatch($sformatf("level_count reads %0d, wrote %0d", readback, count));
    gen_levels = active_levels(count);
  endtask

  // Driver: present queued beats, hold each until taken, idle between
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start     <= 1'b0;
      in_item_i <= '0;
      idle_left = 0;
    end else begin
      if (start && !busy) begin
        if (in_item_i.mode == MODE_LOAD) level_store[in_item_i.level_index] = in_item_i.level_value;
        else awaited_results.push_back(quantize_sample(in_item_i));
      end
      if (start && busy) begin
        // hold the beat until the block takes it
      end else if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (queued_beats.size() != 0) begin
        in_item_i <= queued_beats.pop_front();
        start     <= 1'b1;
        idle_left = $urandom_range(0, gap_max);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check each result beat against the oldest prediction
  result_t want;
  string   diffs;
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (awaited_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result %p", result_o));
      end else begin
        want  = awaited_results.pop_front();
        diffs = "";
        if (result_o.quantized_real !== want.quantized_real)
          diffs = {diffs, $sformatf(" quantized_real %0d want %0d",
                                    result_o.quantized_real, want.quantized_real)};
        if (result_o.quantized_imag !== want.quantized_imag)
          diffs = {diffs, $sformatf(" quantized_imag %0d want %0d",
                                    result_o.quantized_imag, want.quantized_imag)};
        if (result_o.code_real !== want.code_real)
          diffs = {diffs, $sformatf(" code_real %0d want %0d", result_o.code_real, want.code_real)};
        if (result_o.code_imag !== want.code_imag)
          diffs = {diffs, $sformatf(" code_imag %0d want %0d", result_o.code_imag, want.code_imag)};
        if (diffs != "") flag_mismatch({"result", diffs});
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int unsigned phase_counts [$];
    int unsigned phase_end;
    int unsigned pick;
    phase_counts = '{64, 0, 3, 65, 1, 127, 63, 2, 33, 64, 4, 17};
    phase_counts.push_back($urandom_range(0, 127));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: rails of every field, exact hits, a table out of order
    queue_load(0, -16'sd100);
    queue_load(1, 16'sd100);
    queue_load(63, 16'sh7FFF);
    queue_load(62, 16'sh8000);
    queue_quantize(16'sh8000, 16'sh7FFF);
    queue_quantize(-16'sd100, 16'sd100);
    queue_quantize(16'sd99, -16'sd101);
    queue_quantize(16'sd101, 16'sd0);
    queue_load(1, 16'sh8000);
    queue_quantize(16'sh8000, 16'sh7FFF);
    queue_load(0, 16'sh7FFF);
    queue_quantize(16'sd0, -16'sd1);
    queue_load(0, -16'sd100);
    queue_load(1, 16'sd100);
    queue_quantize(16'sd100, -16'sd100);

    // Random phases, one level count each, loads fill the table first
    foreach (phase_counts[p]) begin
      wait_drained();
      repeat (LATENCY + 2) @(posedge clk_i);
      write_level_count(CNT_W'(phase_counts[p]));
      gap_max = (p % 3 == 1) ? 0 : 18;
      @(negedge clk_i);
      phase_end = beats_queued + PHASE_BEATS;
      queue_table(gen_levels);
      while (beats_queued < phase_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 85) queue_quantize(pick_part(), pick_part());
        else if (pick < 96) queue_load($urandom_range(0, MAX_LEVELS - 1), SAMPLE_W'($urandom));
        else queue_table(gen_levels);
      end
    end

    wait_drained();
    repeat (LATENCY + 4) @(posedge clk_i);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
